// ===== design/crc8_response_frame_builder_assert.svh =====
// Assertion macros for the response frame builder.
// They expect clk and rst to be in scope where they are used.
`ifndef CRC8_RESPONSE_FRAME_BUILDER_ASSERT_SVH
`define CRC8_RESPONSE_FRAME_BUILDER_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication.
`define CRC8RFB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define CRC8RFB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CRC8RFB_ASSERT_IMP(lbl, ante, cons, msg)
`define CRC8RFB_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== design/crc8rfb_pkg.sv =====
`default_nettype none

package crc8rfb_pkg;

  localparam logic [7:0] SYNC_BYTE = 8'h5B;

  localparam logic OP_START   = 1'b0;
  localparam logic OP_PAYLOAD = 1'b1;

  // x^(8+i) mod (x^8 + x^7 + x^2 + 1), i = 0..7
  localparam logic [7:0] X8_COL [8] = '{
    8'h85, 8'h8F, 8'h9B, 8'hB3, 8'hE3, 8'h43, 8'h86, 8'h89
  };
  // x^(16+i) mod the same polynomial
  localparam logic [7:0] X16_COL [8] = '{
    8'h97, 8'hAB, 8'hD3, 8'h23, 8'h46, 8'h8C, 8'h9D, 8'hBF
  };

  typedef struct packed {
    logic       opcode;
    logic [7:0] frame_code;
    logic [7:0] frame_length;
    logic [7:0] payload_byte;
  } item_t;

  // Up to four result bytes of one item, sent from index 0 to last.
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last;
    logic            has_check;
  } burst_t;

  // c * x^8 mod P: the CRC register after eight zero bits are shifted in.
  function automatic logic [7:0] crc_x8(input logic [7:0] c);
    logic [7:0] r;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      if (c[i]) r = r ^ X8_COL[i];
    end
    return r;
  endfunction

  // c * x^16 mod P
  function automatic logic [7:0] crc_x16(input logic [7:0] c);
    logic [7:0] r;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      if (c[i]) r = r ^ X16_COL[i];
    end
    return r;
  endfunction

  // Sync byte times x^8; XOR in the code to get the CRC register after
  // sync and code, starting from zero.
  localparam logic [7:0] CRC_SYNC = crc_x8(SYNC_BYTE);

endpackage

`default_nettype wire

// ===== design/crc8rfb_in_stage.sv =====
`default_nettype none

module crc8rfb_in_stage (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               opcode,
  input  wire logic [7:0]         frame_code,
  input  wire logic [7:0]         frame_length,
  input  wire logic [7:0]         payload_byte,
  input  wire logic               take,
  output logic                    item_valid,
  output crc8rfb_pkg::item_t      item
);
  import crc8rfb_pkg::*;

  logic accept;

  assign in_stall = item_valid & ~take;
  assign accept   = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (accept) begin
      item_valid <= 1'b1;
    end else if (take) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item.opcode       <= opcode;
      item.frame_code   <= frame_code;
      item.frame_length <= frame_length;
      item.payload_byte <= payload_byte;
    end
  end

endmodule

`default_nettype wire

// ===== design/crc8rfb_frame_ctl.sv =====
`default_nettype none

module crc8rfb_frame_ctl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                item_valid,
  input  wire crc8rfb_pkg::item_t  item,
  input  wire logic                burst_free,
  output logic                     take,
  output logic                     burst_load,
  output crc8rfb_pkg::burst_t      burst
);
  import crc8rfb_pkg::*;

  logic [7:0] crc_reg, crc_reg_next;
  logic [7:0] bytes_left, bytes_left_next;
  logic       frame_open, frame_open_next;
  logic       load;
  logic       drop;
  logic [7:0] c2;

  always_comb begin
    burst           = '0;
    load            = 1'b0;
    drop            = 1'b0;
    crc_reg_next    = crc_reg;
    bytes_left_next = bytes_left;
    frame_open_next = frame_open;
    c2              = CRC_SYNC ^ item.frame_code;
    if (item_valid) begin
      unique case (item.opcode)
        OP_START: begin
          load           = 1'b1;
          burst.bytes[0] = SYNC_BYTE;
          burst.bytes[1] = item.frame_code;
          burst.bytes[2] = item.frame_length;
          // zero length: check = crc after length, then zero byte
          burst.bytes[3] = crc_x16(c2);
          if (item.frame_length == 8'd0) begin
            burst.last      = 2'd3;
            burst.has_check = 1'b1;
            crc_reg_next    = '0;
            bytes_left_next = '0;
            frame_open_next = 1'b0;
          end else begin
            burst.last      = 2'd2;
            crc_reg_next    = crc_x8(c2) ^ item.frame_length;
            bytes_left_next = item.frame_length;
            frame_open_next = 1'b1;
          end
        end
        OP_PAYLOAD: begin
          if (frame_open && bytes_left != 8'd0) begin
            load           = 1'b1;
            burst.bytes[0] = item.payload_byte;
            burst.bytes[1] = crc_x16(crc_reg) ^ crc_x8(item.payload_byte);
            if (bytes_left == 8'd1) begin
              burst.last      = 2'd1;
              burst.has_check = 1'b1;
              crc_reg_next    = '0;
              bytes_left_next = '0;
              frame_open_next = 1'b0;
            end else begin
              burst.last      = 2'd0;
              crc_reg_next    = crc_x8(crc_reg) ^ item.payload_byte;
              bytes_left_next = bytes_left - 8'd1;
            end
          end else begin
            drop = 1'b1;  // payload outside a frame
          end
        end
        default: ;
      endcase
    end
  end

  assign burst_load = load & burst_free;
  assign take       = drop | burst_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_reg    <= '0;
      bytes_left <= '0;
      frame_open <= 1'b0;
    end else if (take) begin
      crc_reg    <= crc_reg_next;
      bytes_left <= bytes_left_next;
      frame_open <= frame_open_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/crc8rfb_out_stage.sv =====
`default_nettype none

module crc8rfb_out_stage (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                burst_load,
  input  wire crc8rfb_pkg::burst_t burst,
  output logic                     burst_free,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [7:0]               tx_byte,
  output logic                     end_of_run,
  output logic                     end_of_frame
);
  import crc8rfb_pkg::*;

  burst_t     burst_q;
  logic [1:0] idx;
  logic       done;

  assign tx_byte      = burst_q.bytes[idx];
  assign end_of_run   = (idx == burst_q.last);
  assign end_of_frame = end_of_run & burst_q.has_check;
  assign done         = out_valid & ~out_stall & end_of_run;
  assign burst_free   = ~out_valid | done;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else if (burst_load) begin
      out_valid <= 1'b1;
      idx       <= '0;
    end else if (done) begin
      out_valid <= 1'b0;
    end else if (out_valid && !out_stall) begin
      idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (burst_load) begin
      burst_q <= burst;
    end
  end

endmodule

`default_nettype wire

// ===== design/crc8_response_frame_builder.sv =====
// Response frame builder with CRC-8 (poly 0x85) check byte.
// Input channel (in_valid / in_stall): one item per handshake. opcode 0
//   starts a frame: sync 0x5B, frame_code, frame_length go out. opcode 1
//   carries one payload byte, passed through while a frame is open and
//   dropped otherwise. A new start abandons an open frame.
// Output channel (out_valid / out_stall): one frame byte per handshake.
//   end_of_run marks the last byte caused by an item, end_of_frame the
//   check byte, which follows the last payload byte (or the header when
//   the length is zero).
// Path: an accepted item is held in the input register, decoded
//   combinationally and loaded into the burst register once it is free.
// Output: the burst register sends one byte per cycle while out_stall is
//   low; a payload item gives one byte (two for the last one, with the check),
//   a start item three (four with zero length). Dropped items give none.
// A stalled receiver holds the current byte; the input register then
//   fills and in_stall rises until the burst drains.
// Reset (rst, synchronous): empties both registers, closes any frame and
//   clears the CRC.
`default_nettype none
`include "crc8_response_frame_builder_assert.svh"

module crc8_response_frame_builder (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic       opcode,
  input  wire logic [7:0] frame_code,
  input  wire logic [7:0] frame_length,
  input  wire logic [7:0] payload_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      tx_byte,
  output logic            end_of_run,
  output logic            end_of_frame
);
  import crc8rfb_pkg::*;

  item_t  item;
  logic   item_valid;
  logic   take;
  logic   burst_load;
  logic   burst_free;
  burst_t burst;

  // input register
  crc8rfb_in_stage u_in (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .opcode       (opcode),
    .frame_code   (frame_code),
    .frame_length (frame_length),
    .payload_byte (payload_byte),
    .take         (take),
    .item_valid   (item_valid),
    .item         (item)
  );

  // frame state and CRC; builds the byte burst of one item
  crc8rfb_frame_ctl u_ctl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .burst_free (burst_free),
    .take       (take),
    .burst_load (burst_load),
    .burst      (burst)
  );

  // burst register, one byte out per cycle unless out_stall is high
  crc8rfb_out_stage u_out (
    .clk          (clk),
    .rst          (rst),
    .burst_load   (burst_load),
    .burst        (burst),
    .burst_free   (burst_free),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .tx_byte      (tx_byte),
    .end_of_run   (end_of_run),
    .end_of_frame (end_of_frame)
  );

  `CRC8RFB_ASSERT_IMP(a_eof_ends_run, out_valid && end_of_frame, end_of_run, "check byte not last")
  `CRC8RFB_ASSERT_NXT(a_run_continues, out_valid && !out_stall && !end_of_run, out_valid, "burst cut short")
  `CRC8RFB_ASSERT_IMP(a_start_not_dropped, take && !burst_load, item.opcode == OP_PAYLOAD, "start dropped")

endmodule

`default_nettype wire
